// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/tga_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by every decoder module.
package tga_pkg;

    localparam int PIXEL_INDEX_BITS_DEF = 24;
    localparam int OUT_INDEX_W          = 24;
    localparam int BPP_W                = 3;
    localparam int TOTAL_W              = 24;
    localparam int QUEUE_DEPTH          = 2;
    localparam int APB_ADDR_W           = 3;
    localparam int APB_DATA_W           = 32;

    localparam logic [7:0]       RAW_LIMIT  = 8'd128;
    localparam logic [7:0]       RUN_BIAS   = 8'd127;
    localparam logic [BPP_W-1:0] RGBA_BYTES = 3'd4;
    localparam logic [BPP_W-1:0] RGB_BYTES  = 3'd3;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd1;

    // register index, taken from paddr[2]
    localparam logic REG_BPP   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    typedef struct packed {
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [7:0]             alpha;
        logic [7:0]             repeat_count;
        logic [OUT_INDEX_W-1:0] first_index;
        logic                   status;
        logic                   last;
    } result_t;

endpackage

// ===== rtl/core/tga_front.sv =====
// Front end: packet parser and pixel assembler, one byte per cycle while accept is high.
// Depends on tga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tga_front #(
    parameter int PIXEL_INDEX_BITS = tga_pkg::PIXEL_INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_start,
    input  logic                          bpp_rgba,
    input  logic [tga_pkg::TOTAL_W-1:0]   pixel_total,
    output logic                          push,
    output tga_pkg::result_t              result
);
    import tga_pkg::*;

    localparam int PIB = PIXEL_INDEX_BITS;
    localparam int CW  = ((PIB > TOTAL_W) ? PIB : TOTAL_W) + 1;
    localparam logic [CW-1:0] IDX_MAX = CW'((64'd1 << PIB) - 64'd1);

    logic           expect_header_reg, expect_header_next;
    logic           is_run_reg, is_run_next;
    logic [7:0]     pixels_left_reg, pixels_left_next;
    logic [1:0]     byte_pos_reg, byte_pos_next;
    logic [23:0]    gather_reg, gather_next;
    logic [PIB-1:0] pixels_done_reg, pixels_done_next;
    logic           finished_reg, finished_next;

    logic           eh, run, fin;
    logic [7:0]     left;
    logic [1:0]     pos;
    logic [23:0]    gath, gath_upd;
    logic [PIB-1:0] done;
    logic [CW-1:0]  total_eff, total_w;
    logic [7:0]     len, count;
    logic [BPP_W-1:0] bpp;

    always_comb
    begin
        total_w   = CW'(pixel_total);
        total_eff = (total_w > IDX_MAX) ? IDX_MAX : total_w;
        bpp       = bpp_rgba ? RGBA_BYTES : RGB_BYTES;

        // frame start clears everything before this byte is looked at
        eh   = frame_start ? 1'b1 : expect_header_reg;
        run  = frame_start ? 1'b0 : is_run_reg;
        left = frame_start ? 8'd0 : pixels_left_reg;
        pos  = frame_start ? 2'd0 : byte_pos_reg;
        gath = frame_start ? 24'd0 : gather_reg;
        done = frame_start ? '0 : pixels_done_reg;
        fin  = frame_start ? 1'b0 : finished_reg;

        expect_header_next = eh;
        is_run_next        = run;
        pixels_left_next   = left;
        byte_pos_next      = pos;
        gather_next        = gath;
        pixels_done_next   = done;
        finished_next      = fin;

        push     = 1'b0;
        result   = '0;
        len      = (data_byte >= RAW_LIMIT) ? (data_byte - RUN_BIAS) : (data_byte + 8'd1);
        count    = run ? left : 8'd1;
        gath_upd = gath;
        case (pos)
            2'd0:    gath_upd[7:0]   = data_byte;
            2'd1:    gath_upd[15:8]  = data_byte;
            2'd2:    gath_upd[23:16] = data_byte;
            default: gath_upd        = gath;
        endcase

        if (!fin)
        begin
            if (eh)
            begin
                if (CW'(done) + CW'(len) > total_eff)
                begin
                    // refused packet ends the image
                    finished_next       = 1'b1;
                    push                = 1'b1;
                    result.repeat_count = len;
                    result.first_index  = OUT_INDEX_W'(done);
                    result.status       = 1'b1;
                    result.last         = 1'b1;
                end
                else
                begin
                    is_run_next        = (data_byte >= RAW_LIMIT);
                    pixels_left_next   = len;
                    byte_pos_next      = 2'd0;
                    gather_next        = 24'd0;
                    expect_header_next = 1'b0;
                end
            end
            else if (({1'b0, pos} + 3'd1) < bpp)
            begin
                byte_pos_next = pos + 2'd1;
                gather_next   = gath_upd;
            end
            else
            begin
                byte_pos_next      = 2'd0;
                gather_next        = 24'd0;
                pixels_left_next   = run ? 8'd0 : (left - 8'd1);
                pixels_done_next   = done + PIB'(count);
                expect_header_next = (pixels_left_next == 8'd0);
                finished_next      = (CW'(pixels_done_next) >= total_eff);
                push                = 1'b1;
                result.blue         = gath_upd[7:0];
                result.green        = gath_upd[15:8];
                result.red          = gath_upd[23:16];
                result.alpha        = bpp_rgba ? data_byte : 8'd0;
                result.repeat_count = count;
                result.first_index  = OUT_INDEX_W'(done);
                result.status       = 1'b0;
                result.last         = finished_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            is_run_reg        <= 1'b0;
            pixels_left_reg   <= 8'd0;
            byte_pos_reg      <= 2'd0;
            gather_reg        <= 24'd0;
            pixels_done_reg   <= '0;
            finished_reg      <= 1'b0;
        end
        else if (accept)
        begin
            expect_header_reg <= expect_header_next;
            is_run_reg        <= is_run_next;
            pixels_left_reg   <= pixels_left_next;
            byte_pos_reg      <= byte_pos_next;
            gather_reg        <= gather_next;
            pixels_done_reg   <= pixels_done_next;
            finished_reg      <= finished_next;
        end
    end

    `ASSERT_IMP(a_err_is_last, push && result.status, result.last, "error word without last")
    `ASSERT_NXT(a_last_stops, accept && push && result.last, finished_reg,
                "image not finished after last word")

endmodule

// ===== rtl/core/tga_queue.sv =====
// Short result queue between the front end and the output stage.
// Depends on tga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tga_queue #(
    parameter int DEPTH = tga_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tga_pkg::result_t  push_word,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output tga_pkg::result_t  head_word
);
    import tga_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    `ASSERT_IMP(a_no_overflow, push && full, pop, "push into full queue")
    `ASSERT_IMP(a_no_underflow, pop, not_empty, "pop from empty queue")

endmodule

// ===== rtl/core/tga_back.sv =====
// Output stage: registered result word with valid/stall handshake.
// Depends on tga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tga_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  tga_pkg::result_t  q_head,
    output logic              q_pop,
    input  logic              out_stall,
    output logic              out_valid,
    output tga_pkg::result_t  out_word
);
    import tga_pkg::*;

    logic    valid_reg, valid_next;
    result_t word_reg;

    // take the queue head whenever the output slot is free or drains now
    assign q_pop      = q_not_empty && (!valid_reg || !out_stall);
    assign valid_next = q_pop ? 1'b1 : (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            word_reg <= q_head;
    end

    `ASSERT_NXT(a_drain, valid_reg && !out_stall && !q_not_empty, !valid_reg,
                "output valid without a queued word")

endmodule

// ===== rtl/core/tga_rle_pixel_decoder_core.sv =====
// TGA run-length pixel decoder: top level with APB config registers.
// Depends on tga_pkg, tga_front, tga_queue, tga_back.
// Each accepted byte that completes a pixel (or a refused header) yields a
// result word that passes through the queue and then the output register.
// Throughput: 1 byte per cycle unless in_stall, bounded by the parser update.
// Reset: counters cleared, parser waits for a header, config = 3 bpp, 1 pixel.
module tga_rle_pixel_decoder_core #(
    parameter int PIXEL_INDEX_BITS = tga_pkg::PIXEL_INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tga_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tga_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tga_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // byte stream in
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             frame_start,
    // result words out
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic [7:0]                       alpha,
    output logic [7:0]                       repeat_count,
    output logic [tga_pkg::OUT_INDEX_W-1:0]  first_index,
    output logic                             status,
    output logic                             last
);
    import tga_pkg::*;

    logic [BPP_W-1:0]   bpp_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               cfg_wr;

    logic    accept;
    logic    push;
    result_t front_word;
    logic    q_full, q_not_empty, q_pop;
    result_t q_head;
    result_t out_word;

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_BPP:   bpp_reg   <= pwdata[BPP_W-1:0];
                REG_TOTAL: total_reg <= pwdata[TOTAL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BPP:   prdata = APB_DATA_W'(bpp_reg);
            REG_TOTAL: prdata = APB_DATA_W'(total_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- input handshake ----------------
    // Stall only when the queue is full and no word leaves it this cycle.
    assign in_stall = q_full && !q_pop;
    assign accept   = in_valid && !in_stall;

    tga_front #(
        .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .bpp_rgba    (bpp_reg == RGBA_BYTES),
        .pixel_total (total_reg),
        .push        (push),
        .result      (front_word)
    );

    tga_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && push),
        .push_word (front_word),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_word (q_head)
    );

    tga_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_word    (out_word)
    );

    // ---------------- result word fields ----------------
    assign red          = out_word.red;
    assign green        = out_word.green;
    assign blue         = out_word.blue;
    assign alpha        = out_word.alpha;
    assign repeat_count = out_word.repeat_count;
    assign first_index  = out_word.first_index;
    assign status       = out_word.status;
    assign last         = out_word.last;

endmodule
